@@ rtl/core/tep_pkg.sv @@
// ----------------------------------------------------------------------------
// tep_pkg
// Shared widths, register codes, divider cell record and orbit unit records
// for the tricorn escape-time pixel core.
// ----------------------------------------------------------------------------
`default_nettype none

package tep_pkg;

   localparam int COORD_W         = 32;
   localparam int FRAC_BITS       = 28;
   localparam int ZOOM_FRAC       = 16;
   localparam int DIM_W           = 13;
   localparam int PIX_W           = 12;
   localparam int CNT_W           = 10;
   localparam int PAL_W           = 8;
   localparam int ZOOM_W          = 32;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 32;
   localparam int MAX_DIMENSION   = 4096;
   localparam int ITERATION_LIMIT = 1023;
   localparam int QUO_W           = 32;
   localparam int DIV_CELLS       = QUO_W;
   localparam int MAG_W           = 14;
   localparam int PRE_SHIFT       = ZOOM_FRAC + FRAC_BITS - QUO_W;
   localparam int DEN_W           = ZOOM_W + $clog2(MAX_DIMENSION);
   localparam int REM_W           = DEN_W;
   localparam int NXT_W           = 36;
   localparam int PROD_W          = 2 * COORD_W;

   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ZOOM_FACTOR   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_REAL   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_IMAG   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ITERATION_CAP = 3'd5;

   localparam logic AXIS_RE = 1'b0;
   localparam logic AXIS_IM = 1'b1;

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef struct packed {
      logic              valid;
      logic              axis;
      logic              neg;
      logic              ovf;
      logic [REM_W-1:0]  rem;
      logic [DEN_W-1:0]  den;
      logic [QUO_W-1:0]  quo;
   } tep_div_type;

   typedef struct packed {
      logic                      start;
      logic signed [COORD_W-1:0] c_re;
      logic signed [COORD_W-1:0] c_im;
      logic [CNT_W-1:0]          cap;
   } tep_orbit_cmd_type;

   typedef struct packed {
      logic             done;
      logic [CNT_W-1:0] count;
   } tep_orbit_rsp_type;

   function automatic logic signed [COORD_W-1:0] sat_coord(
      input logic signed [COORD_W+1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > (COORD_W+2)'(COORD_MAX)) begin
         r = COORD_MAX;
      end else if (v < (COORD_W+2)'(COORD_MIN)) begin
         r = COORD_MIN;
      end else begin
         r = COORD_W'(v);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/tep_div_cell.sv @@
// ----------------------------------------------------------------------------
// tep_div_cell
// One restoring-division cell: shifts the partial remainder, trial-subtracts
// the divisor and appends one quotient bit, then hands the record on.
// ----------------------------------------------------------------------------
`default_nettype none

module tep_div_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  tep_pkg::tep_div_type prev_cell,
   output tep_pkg::tep_div_type next_cell
);

   logic [tep_pkg::REM_W:0] shifted;
   logic                    fits;
   tep_pkg::tep_div_type    stage_in;
   tep_pkg::tep_div_type    stage_ff;

   always_comb begin
      shifted  = {prev_cell.rem, 1'b0};
      fits     = shifted >= {1'b0, prev_cell.den};
      stage_in = prev_cell;
      if (fits) begin
         stage_in.rem = tep_pkg::REM_W'(shifted - {1'b0, prev_cell.den});
      end else begin
         stage_in.rem = shifted[tep_pkg::REM_W-1:0];
      end
      stage_in.quo = {prev_cell.quo[tep_pkg::QUO_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end
   end

   assign next_cell = stage_ff;

endmodule

`default_nettype wire

@@ rtl/core/tep_orbit.sv @@
// ----------------------------------------------------------------------------
// tep_orbit
// Tricorn orbit unit: alternates a product phase and an update phase per
// iteration, testing escape of each candidate from its own squares.
// ----------------------------------------------------------------------------
`default_nettype none

module tep_orbit (
   input  logic                       clock,
   input  logic                       reset,
   input  tep_pkg::tep_orbit_cmd_type cmd,
   output tep_pkg::tep_orbit_rsp_type rsp
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_PROD = 2'd1;
   localparam logic [1:0] PH_UPD  = 2'd2;

   localparam int CW = tep_pkg::COORD_W;
   localparam int NW = tep_pkg::NXT_W;
   localparam int PW = tep_pkg::PROD_W;
   localparam int KW = tep_pkg::CNT_W;

   localparam logic signed [NW-1:0] LIM  = NW'(1) <<< (tep_pkg::FRAC_BITS + 2);
   localparam logic [PW:0]          FOUR = (PW+1)'(1) << (2 * tep_pkg::FRAC_BITS + 2);

   logic [1:0]              phase_ff, phase_in;
   logic signed [CW-1:0]    zr_ff, zr_in, zi_ff, zi_in;
   logic signed [CW-1:0]    cre_ff, cre_in, cim_ff, cim_in;
   logic                    big_ff, big_in;
   logic [KW-1:0]           cnt_ff, cnt_in, cap_ff, cap_in, count_ff, count_in;
   logic                    done_ff, done_in;
   logic signed [PW-1:0]    rr_ff, rr_in, ii_ff, ii_in, ri_ff, ri_in;
   logic [PW:0]             mag_sum;
   logic                    escape;
   logic signed [PW+1:0]    twice_neg;
   logic signed [NW-1:0]    nre, nim;
   logic [KW-1:0]           cap_eff, cnt_inc;

   function automatic logic out_of_range(input logic signed [NW-1:0] v);
      return (v >= LIM) || (v <= -LIM);
   endfunction

   always_comb begin
      rr_in = zr_ff * zr_ff;
      ii_in = zi_ff * zi_ff;
      ri_in = zr_ff * zi_ff;

      mag_sum   = {1'b0, rr_ff} + {1'b0, ii_ff};
      escape    = big_ff || (mag_sum > FOUR);
      twice_neg = (PW+2)'(0) - (PW+2)'($signed({ri_ff, 1'b0}));
      nre = NW'(rr_ff >>> tep_pkg::FRAC_BITS) - NW'(ii_ff >>> tep_pkg::FRAC_BITS)
            + NW'(cre_ff);
      nim = NW'(twice_neg >>> tep_pkg::FRAC_BITS) + NW'(cim_ff);

      cap_eff = (cmd.cap > KW'(tep_pkg::ITERATION_LIMIT)) ?
                KW'(tep_pkg::ITERATION_LIMIT) : cmd.cap;
      cnt_inc = cnt_ff + KW'(1);

      phase_in = phase_ff;
      zr_in    = zr_ff;
      zi_in    = zi_ff;
      cre_in   = cre_ff;
      cim_in   = cim_ff;
      big_in   = big_ff;
      cnt_in   = cnt_ff;
      cap_in   = cap_ff;
      count_in = count_ff;
      done_in  = 1'b0;

      case (phase_ff)
         PH_IDLE: begin
            if (cmd.start) begin
               cre_in = cmd.c_re;
               cim_in = cmd.c_im;
               cap_in = cap_eff;
               cnt_in = '0;
               if (cap_eff == '0) begin
                  done_in  = 1'b1;
                  count_in = '0;
               end else begin
                  zr_in    = cmd.c_re;
                  zi_in    = cmd.c_im;
                  big_in   = out_of_range(NW'(cmd.c_re)) || out_of_range(NW'(cmd.c_im));
                  phase_in = PH_PROD;
               end
            end
         end
         PH_PROD: begin
            phase_in = PH_UPD;
         end
         PH_UPD: begin
            if (escape) begin
               done_in  = 1'b1;
               count_in = cnt_ff;
               phase_in = PH_IDLE;
            end else begin
               cnt_in = cnt_inc;
               if (cnt_inc == cap_ff) begin
                  done_in  = 1'b1;
                  count_in = cnt_inc;
                  phase_in = PH_IDLE;
               end else begin
                  zr_in    = CW'(nre);
                  zi_in    = CW'(nim);
                  big_in   = out_of_range(nre) || out_of_range(nim);
                  phase_in = PH_PROD;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      zr_ff    <= zr_in;
      zi_ff    <= zi_in;
      cre_ff   <= cre_in;
      cim_ff   <= cim_in;
      big_ff   <= big_in;
      cnt_ff   <= cnt_in;
      cap_ff   <= cap_in;
      count_ff <= count_in;
      rr_ff    <= rr_in;
      ii_ff    <= ii_in;
      ri_ff    <= ri_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.count = count_ff;

endmodule

`default_nettype wire

@@ rtl/core/tricorn_escape_time_pixel_core.sv @@
// ----------------------------------------------------------------------------
// tricorn_escape_time_pixel_core
// Maps a pixel to a point c, divides through a chain of division cells and
// runs the tricorn orbit to an iteration count.
//
//   channel   direction  payload
//   req_      in         pixel_x, pixel_y
//   rsp_      out        iteration_count, palette_index
//   csr_      in         write enable, index, data (no read-back)
//
// One pixel at a time: a request is taken only while idle, then the pixel passes
// the mapping, the 32-cell divider chain and the orbit loop, which runs N
// iterations (at most 1023, the cap being clamped to that limit).
// Reset is synchronous; it clears control state and loads the configuration defaults.
// A held result stalls only the end of the next pixel; a new request is
// taken as soon as the previous result sits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tricorn_escape_time_pixel_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [tep_pkg::PIX_W-1:0]        req_pixel_x,
   input  logic [tep_pkg::PIX_W-1:0]        req_pixel_y,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [tep_pkg::CNT_W-1:0]        rsp_iteration_count,
   output logic [tep_pkg::PAL_W-1:0]        rsp_palette_index,
   input  logic                             csr_we,
   input  logic [tep_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tep_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MAP    = 3'd1;
   localparam logic [2:0] ST_FEED   = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_SUM    = 3'd4;
   localparam logic [2:0] ST_LAUNCH = 3'd5;
   localparam logic [2:0] ST_RUN    = 3'd6;
   localparam logic [2:0] ST_HOLD   = 3'd7;

   localparam int CW = tep_pkg::COORD_W;
   localparam int DW = tep_pkg::DIM_W;
   localparam int KW = tep_pkg::CNT_W;
   localparam logic signed [CW+1:0] HALF = (CW+2)'(1) <<< (tep_pkg::FRAC_BITS - 1);

   logic [DW-1:0]               width_ff, height_ff;
   logic [tep_pkg::ZOOM_W-1:0]  zoom_ff;
   logic signed [CW-1:0]        off_re_ff, off_im_ff;
   logic [KW-1:0]               cap_ff;

   logic [2:0]                  state_ff, state_in;
   logic [tep_pkg::PIX_W-1:0]   px_ff, py_ff;
   tep_pkg::tep_div_type        head_ff, head_in, spare_ff, spare_in;
   tep_pkg::tep_div_type        chain [tep_pkg::DIV_CELLS+1];
   tep_pkg::tep_div_type        tail;
   logic signed [CW-1:0]        qre_ff, qim_ff, cre_ff, cim_ff;
   logic [KW-1:0]               hold_ff, rsp_count_ff;
   logic                        rsp_valid_ff;
   logic                        out_free;
   tep_pkg::tep_orbit_cmd_type  orbit_cmd;
   tep_pkg::tep_orbit_rsp_type  orbit_rsp;

   function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] d);
      logic [DW-1:0] r;
      if (d == '0) begin
         r = DW'(1);
      end else if (d > DW'(tep_pkg::MAX_DIMENSION)) begin
         r = DW'(tep_pkg::MAX_DIMENSION);
      end else begin
         r = d;
      end
      return r;
   endfunction

   function automatic tep_pkg::tep_div_type prep_axis(
      input logic [tep_pkg::PIX_W-1:0]  p,
      input logic [DW-1:0]              d,
      input logic signed [2:0]          scale,
      input logic [tep_pkg::ZOOM_W-1:0] zm,
      input logic                       axis);
      tep_pkg::tep_div_type              r;
      logic [DW-1:0]                     half;
      logic signed [tep_pkg::MAG_W-1:0]  diff;
      logic signed [15:0]                scaled;
      logic [tep_pkg::MAG_W-1:0]         mag;
      logic [tep_pkg::DEN_W-1:0]         num_hi;
      half   = d >> 1;
      diff   = $signed({2'b00, p}) - $signed({1'b0, half});
      scaled = 16'(diff) * 16'(scale);
      mag    = scaled[15] ? tep_pkg::MAG_W'(-scaled) : tep_pkg::MAG_W'(scaled);
      num_hi = tep_pkg::DEN_W'({mag, {tep_pkg::PRE_SHIFT{1'b0}}});
      r.valid = 1'b1;
      r.axis  = axis;
      r.neg   = scaled[15];
      r.den   = tep_pkg::DEN_W'(zm) * tep_pkg::DEN_W'(d);
      r.ovf   = num_hi >= r.den;
      r.rem   = num_hi;
      r.quo   = '0;
      return r;
   endfunction

   function automatic logic signed [CW-1:0] quo_to_coord(
      input tep_pkg::tep_div_type t);
      logic signed [CW-1:0] r;
      if (t.ovf) begin
         r = t.neg ? tep_pkg::COORD_MIN : tep_pkg::COORD_MAX;
      end else if (t.neg) begin
         r = (t.quo > tep_pkg::QUO_W'(tep_pkg::COORD_MIN)) ?
             tep_pkg::COORD_MIN : $signed(CW'(tep_pkg::QUO_W'(0) - t.quo));
      end else begin
         r = (t.quo > tep_pkg::QUO_W'(tep_pkg::COORD_MAX)) ?
             tep_pkg::COORD_MAX : $signed(CW'(t.quo));
      end
      return r;
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DW'(640);
         height_ff <= DW'(480);
         zoom_ff   <= tep_pkg::ZOOM_W'(65536);
         off_re_ff <= '0;
         off_im_ff <= '0;
         cap_ff    <= KW'(64);
      end else if (csr_we) begin
         case (csr_index)
            tep_pkg::REG_SCREEN_WIDTH:  width_ff  <= csr_wdata[DW-1:0];
            tep_pkg::REG_SCREEN_HEIGHT: height_ff <= csr_wdata[DW-1:0];
            tep_pkg::REG_ZOOM_FACTOR:   zoom_ff   <= csr_wdata[tep_pkg::ZOOM_W-1:0];
            tep_pkg::REG_OFFSET_REAL:   off_re_ff <= $signed(csr_wdata[CW-1:0]);
            tep_pkg::REG_OFFSET_IMAG:   off_im_ff <= $signed(csr_wdata[CW-1:0]);
            tep_pkg::REG_ITERATION_CAP: cap_ff    <= csr_wdata[KW-1:0];
            default: ;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign tail     = chain[tep_pkg::DIV_CELLS];

   always_comb begin
      logic [tep_pkg::ZOOM_W-1:0] zm;
      zm       = (zoom_ff == '0) ? tep_pkg::ZOOM_W'(1) : zoom_ff;
      state_in = state_ff;
      head_in  = head_ff;
      head_in.valid = 1'b0;
      spare_in = prep_axis(py_ff, clamp_dim(height_ff), 3'sd2, zm, tep_pkg::AXIS_IM);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            head_in  = prep_axis(px_ff, clamp_dim(width_ff), 3'sd3, zm, tep_pkg::AXIS_RE);
            state_in = ST_FEED;
         end
         ST_FEED: begin
            head_in  = spare_ff;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (tail.valid && (tail.axis == tep_pkg::AXIS_IM)) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM:    state_in = ST_LAUNCH;
         ST_LAUNCH: state_in = ST_RUN;
         ST_RUN: begin
            if (orbit_rsp.done) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff.valid <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         if (state_ff == ST_HOLD && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      spare_ff <= spare_in;
      if (state_ff == ST_IDLE && req_valid) begin
         px_ff <= req_pixel_x;
         py_ff <= req_pixel_y;
      end
      if (state_ff == ST_DIV && tail.valid) begin
         if (tail.axis == tep_pkg::AXIS_RE) begin
            qre_ff <= quo_to_coord(tail);
         end else begin
            qim_ff <= quo_to_coord(tail);
         end
      end
      if (state_ff == ST_SUM) begin
         cre_ff <= tep_pkg::sat_coord((CW+2)'(qre_ff) + (CW+2)'(off_re_ff) - HALF);
         cim_ff <= tep_pkg::sat_coord((CW+2)'(qim_ff) + (CW+2)'(off_im_ff));
      end
      if (state_ff == ST_RUN && orbit_rsp.done) begin
         hold_ff <= orbit_rsp.count;
      end
      if (state_ff == ST_HOLD && out_free) begin
         rsp_count_ff <= hold_ff;
      end
   end

   assign chain[0] = head_ff;

   genvar g;
   generate
      for (g = 0; g < tep_pkg::DIV_CELLS; g++) begin : g_cell
         tep_div_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .prev_cell (chain[g]),
            .next_cell (chain[g+1])
         );
      end
   endgenerate

   assign orbit_cmd.start = (state_ff == ST_LAUNCH);
   assign orbit_cmd.c_re  = cre_ff;
   assign orbit_cmd.c_im  = cim_ff;
   assign orbit_cmd.cap   = cap_ff;

   tep_orbit u_orbit (
      .clock (clock),
      .reset (reset),
      .cmd   (orbit_cmd),
      .rsp   (orbit_rsp)
   );

   assign req_ready           = (state_ff == ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_iteration_count = rsp_count_ff;
   assign rsp_palette_index   = rsp_count_ff[tep_pkg::PAL_W-1:0];

endmodule

`default_nettype wire

@@ rtl/core/tep_checker.sv @@
// ----------------------------------------------------------------------------
// tep_checker
// Port-level checks for the tricorn escape-time pixel core.
// ----------------------------------------------------------------------------
`default_nettype none

module tep_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [tep_pkg::CNT_W-1:0] rsp_iteration_count,
   input logic [tep_pkg::PAL_W-1:0] rsp_palette_index
);

   a_palette: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_palette_index == rsp_iteration_count[tep_pkg::PAL_W-1:0])
      else $error("palette index differs from low count bits");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction taken while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_iteration_count))
      else $error("stalled response dropped or changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("core not idle after reset");

endmodule

bind tricorn_escape_time_pixel_core tep_checker u_tep_checker (.*);

`default_nettype wire
